FILE: rtl/core/u16550_pkg.sv
`default_nettype none
package u16550_pkg;

   localparam int unsigned REG_BASE_DEFAULT = 4096;

   localparam logic [15:0] OFS_BUF = 16'h0000;
   localparam logic [15:0] OFS_IER = 16'h0004;
   localparam logic [15:0] OFS_FCR = 16'h0008;
   localparam logic [15:0] OFS_LCR = 16'h000c;
   localparam logic [15:0] OFS_LSR = 16'h0014;

   localparam logic [31:0] LSR_DATA  = 32'h0000_0001;
   localparam logic [31:0] LSR_TXRDY = 32'h0000_0020;
   localparam logic [31:0] IER_RX    = 32'h0000_0001;
   localparam int unsigned LCR_DLAB_BIT = 7;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_IDLE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_RBR  = 3'd1,
      TGT_THR  = 3'd2,
      TGT_DLL  = 3'd3,
      TGT_IER  = 3'd4,
      TGT_DLM  = 3'd5,
      TGT_FCR  = 3'd6,
      TGT_LCR  = 3'd7
   } target_type;

   typedef struct packed {
      logic       err;
      logic       lsr;
      target_type tgt;
   } dec_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        irq_level;
      logic        tx_valid;
      logic [7:0]  tx_byte;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/u16550_decode.sv
`default_nettype none
module u16550_decode
   import u16550_pkg::*;
#(
   parameter int unsigned REG_BASE = REG_BASE_DEFAULT
) (
   input  wire logic [1:0]  action,
   input  wire logic [15:0] offset,
   input  wire logic        dlab,
   output dec_type          dec
);

   localparam logic [15:0] Base = REG_BASE[15:0];

   logic is_rd;
   logic is_wr;

   assign is_rd = (action == ACT_READ);
   assign is_wr = (action == ACT_WRITE);

   always_comb begin
      dec.err = 1'b0;
      dec.lsr = 1'b0;
      dec.tgt = TGT_NONE;
      if (is_rd || is_wr) begin
         if (offset == Base + OFS_BUF) begin
            if (dlab) begin
               dec.tgt = TGT_DLL;
            end else if (is_wr) begin
               dec.tgt = TGT_THR;
            end else begin
               dec.tgt = TGT_RBR;
            end
         end else if (offset == Base + OFS_IER) begin
            dec.tgt = dlab ? TGT_DLM : TGT_IER;
         end else if (offset == Base + OFS_FCR) begin
            if (is_wr || dlab) begin
               dec.tgt = TGT_FCR;
            end else begin
               dec.err = 1'b1;
            end
         end else if (offset == Base + OFS_LCR) begin
            dec.tgt = TGT_LCR;
         end else if (offset == Base + OFS_LSR) begin
            dec.lsr = 1'b1;
         end else begin
            dec.err = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/u16550_regs.sv
`default_nettype none
module u16550_regs
   import u16550_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        exec,
   input  wire logic [1:0]  action,
   input  wire logic [31:0] write_data,
   input  wire logic        rx_valid,
   input  wire logic [7:0]  rx_byte,
   input  wire dec_type     dec,
   output logic             dlab,
   output result_type       result
);

   logic [7:0]  rbr_ff, rbr_in;
   logic [31:0] thr_ff, thr_in;
   logic [31:0] ier_ff, ier_in;
   logic [31:0] fcr_ff, fcr_in;
   logic [31:0] lcr_ff, lcr_in;
   logic [31:0] lsr_ff, lsr_in;
   logic [31:0] dll_ff, dll_in;
   logic [31:0] dlm_ff, dlm_in;
   logic        irq_ff, irq_in;

   assign dlab = lcr_ff[LCR_DLAB_BIT];

   always_comb begin
      rbr_in = rbr_ff;
      thr_in = thr_ff;
      ier_in = ier_ff;
      fcr_in = fcr_ff;
      lcr_in = lcr_ff;
      lsr_in = lsr_ff;
      dll_in = dll_ff;
      dlm_in = dlm_ff;
      irq_in = irq_ff;
      result.read_data    = '0;
      result.access_error = 1'b0;
      result.tx_valid     = 1'b0;
      result.tx_byte      = '0;
      case (action)
         ACT_READ: begin
            result.access_error = dec.err;
            if (dec.lsr) begin
               result.read_data = lsr_ff;
            end else begin
               case (dec.tgt)
                  TGT_RBR: begin
                     result.read_data = {24'd0, rbr_ff};
                     lsr_in = lsr_ff & ~LSR_DATA;
                     irq_in = 1'b0;
                  end
                  TGT_DLL: result.read_data = dll_ff;
                  TGT_IER: result.read_data = ier_ff;
                  TGT_DLM: result.read_data = dlm_ff;
                  TGT_FCR: result.read_data = fcr_ff;
                  TGT_LCR: result.read_data = lcr_ff;
                  default: result.read_data = '0;
               endcase
            end
         end
         ACT_WRITE: begin
            result.access_error = dec.err;
            if (dec.lsr) begin
               lsr_in = write_data;
            end else begin
               case (dec.tgt)
                  TGT_THR: begin
                     thr_in = write_data;
                     lsr_in = lsr_ff & ~LSR_TXRDY;
                  end
                  TGT_DLL: dll_in = write_data;
                  TGT_IER: ier_in = write_data;
                  TGT_DLM: dlm_in = write_data;
                  TGT_FCR: fcr_in = write_data;
                  TGT_LCR: lcr_in = write_data;
                  default: ;
               endcase
            end
         end
         ACT_TICK: begin
            if (rx_valid) begin
               rbr_in = rx_byte;
               lsr_in = lsr_ff | LSR_DATA;
               if ((ier_ff & IER_RX) != '0) begin
                  irq_in = 1'b1;
               end
            end
            if ((lsr_ff & LSR_TXRDY) == '0) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = thr_ff[7:0];
               lsr_in = lsr_in | LSR_TXRDY;
            end
         end
         default: ;
      endcase
      result.irq_level = irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbr_ff <= '0;
         thr_ff <= '0;
         ier_ff <= '0;
         fcr_ff <= '0;
         lcr_ff <= '0;
         lsr_ff <= LSR_TXRDY;
         dll_ff <= '0;
         dlm_ff <= '0;
         irq_ff <= 1'b0;
      end else if (exec) begin
         rbr_ff <= rbr_in;
         thr_ff <= thr_in;
         ier_ff <= ier_in;
         fcr_ff <= fcr_in;
         lcr_ff <= lcr_in;
         lsr_ff <= lsr_in;
         dll_ff <= dll_in;
         dlm_ff <= dlm_in;
         irq_ff <= irq_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/uart_16550_register_model_core.sv
// A request beat is held in the request register, its result in the
// response register, written by the register decode and update logic.
// Throughput: one beat per cycle unless rsp_ready stalls the response.
// Reset is synchronous and active high; it empties both pipeline registers
// and returns every UART register to its reset value (line status 0x20).
`default_nettype none
module uart_16550_register_model_core
   import u16550_pkg::*;
#(
   parameter int unsigned REG_BASE = REG_BASE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_offset,
   input  wire logic [31:0] req_write_data,
   input  wire logic        req_rx_valid,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_access_error,
   output logic             rsp_irq_level,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  action_ff;
   logic [15:0] offset_ff;
   logic [31:0] wdata_ff;
   logic        rxv_ff;
   logic [7:0]  rxb_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff;
   result_type  result;
   dec_type     dec;
   logic        dlab;
   logic        advance;
   logic        exec;
   logic        take;

   assign advance = !out_valid_ff || rsp_ready;
   assign exec    = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take    = req_valid && req_ready;

   assign in_valid_in  = take ? 1'b1 : (exec ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   u16550_decode #(
      .REG_BASE(REG_BASE)
   ) u_decode (
      .action (action_ff),
      .offset (offset_ff),
      .dlab   (dlab),
      .dec    (dec)
   );

   u16550_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .action     (action_ff),
      .write_data (wdata_ff),
      .rx_valid   (rxv_ff),
      .rx_byte    (rxb_ff),
      .dec        (dec),
      .dlab       (dlab),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff <= req_action;
         offset_ff <= req_offset;
         wdata_ff  <= req_write_data;
         rxv_ff    <= req_rx_valid;
         rxb_ff    <= req_rx_byte;
      end
      if (exec) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = result_ff.read_data;
   assign rsp_access_error = result_ff.access_error;
   assign rsp_irq_level    = result_ff.irq_level;
   assign rsp_tx_valid     = result_ff.tx_valid;
   assign rsp_tx_byte      = result_ff.tx_byte;

`ifndef SYNTHESIS
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_access_error |-> rsp_read_data == 32'd0)
      else $error("error beat carries read data");

   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> !rsp_access_error && rsp_read_data == 32'd0)
      else $error("transmit beat carries bus result");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("request stalled with empty response stage");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      exec |=> out_valid_ff)
      else $error("executed beat did not reach response stage");
`endif

endmodule
`default_nettype wire

FILE: verif/uart_16550_register_model_core_test.sv
`default_nettype none
module uart_16550_register_model_core_test;
   import u16550_pkg::*;

   localparam logic [15:0] BASE = 16'(REG_BASE_DEFAULT);
   localparam logic [15:0] A_BUF = BASE + OFS_BUF;
   localparam logic [15:0] A_IER = BASE + OFS_IER;
   localparam logic [15:0] A_FCR = BASE + OFS_FCR;
   localparam logic [15:0] A_LCR = BASE + OFS_LCR;
   localparam logic [15:0] A_MCR = BASE + 16'h0010;
   localparam logic [15:0] A_LSR = BASE + OFS_LSR;
   localparam logic [15:0] A_MSR = BASE + 16'h0018;
   localparam logic [15:0] A_SCR = BASE + 16'h001c;
   localparam int RANDOM_ITEMS = 1850;
   localparam int IDLE_PERCENT = 34;

   class uart_reg_mirror;
      logic [7:0]  rx_buf;
      logic [31:0] thr, ier, fcr, lcr, lsr, dll, dlm;
      logic        irq;
      result_type  expected_rsp[$];
      int          mismatches;

      function new();
         rx_buf = '0;
         thr = '0;
         ier = '0;
         fcr = '0;
         lcr = '0;
         lsr = LSR_TXRDY;
         dll = '0;
         dlm = '0;
         irq = 1'b0;
         mismatches = 0;
      endfunction

      function void apply_request(action_type act, logic [15:0] ofs, logic [31:0] wd,
                                  logic rxv, logic [7:0] rxb);
         result_type r;
         logic       dlab;
         logic       wr;
         r = '0;
         dlab = lcr[LCR_DLAB_BIT];
         wr = (act == ACT_WRITE);
         if (act == ACT_READ || act == ACT_WRITE) begin
            if (ofs == A_BUF) begin
               if (dlab) begin
                  if (wr) dll = wd;
                  else r.read_data = dll;
               end else if (wr) begin
                  thr = wd;
                  lsr &= ~LSR_TXRDY;
               end else begin
                  r.read_data = {24'b0, rx_buf};
                  lsr &= ~LSR_DATA;
                  irq = 1'b0;
               end
            end else if (ofs == A_IER) begin
               if (dlab) begin
                  if (wr) dlm = wd;
                  else r.read_data = dlm;
               end else begin
                  if (wr) ier = wd;
                  else r.read_data = ier;
               end
            end else if (ofs == A_FCR) begin
               if (wr) fcr = wd;
               else if (dlab) r.read_data = fcr;
               else r.access_error = 1'b1;
            end else if (ofs == A_LCR) begin
               if (wr) lcr = wd;
               else r.read_data = lcr;
            end else if (ofs == A_LSR) begin
               if (wr) lsr = wd;
               else r.read_data = lsr;
            end else begin
               r.access_error = 1'b1;
            end
         end else if (act == ACT_TICK) begin
            if (rxv) begin
               rx_buf = rxb;
               lsr |= LSR_DATA;
               if ((ier & IER_RX) != 0) irq = 1'b1;
            end
            if ((lsr & LSR_TXRDY) == 0) begin
               r.tx_valid = 1'b1;
               r.tx_byte = thr[7:0];
               lsr |= LSR_TXRDY;
            end
         end
         r.irq_level = irq;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
         if (exp_val !== got_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
         end
      endfunction

      function void compare_response(result_type got);
         result_type exp_val;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response beat, expected none, actual %0h",
                     $time, got);
            return;
         end
         exp_val = expected_rsp.pop_front();
         compare_field("read_data", exp_val.read_data, got.read_data);
         compare_field("access_error", 32'(exp_val.access_error), 32'(got.access_error));
         compare_field("irq_level", 32'(exp_val.irq_level), 32'(got.irq_level));
         compare_field("tx_valid", 32'(exp_val.tx_valid), 32'(got.tx_valid));
         compare_field("tx_byte", 32'(exp_val.tx_byte), 32'(got.tx_byte));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [15:0] req_offset;
   logic [31:0] req_write_data;
   logic        req_rx_valid;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_access_error;
   logic        rsp_irq_level;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;

   uart_reg_mirror mirror;
   int             beats_sent;
   logic           quiet;

   uart_16550_register_model_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_rx_valid(req_rx_valid),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_access_error(rsp_access_error),
      .rsp_irq_level(rsp_irq_level),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Each call is entered at a falling edge and returns at the falling edge after its beat.
   task automatic send_request(action_type act, logic [15:0] ofs, logic [31:0] wd,
                               logic rxv, logic [7:0] rxb);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_offset <= ofs;
      req_write_data <= wd;
      req_rx_valid <= rxv;
      req_rx_byte <= rxb;
      do @(posedge clock); while (!req_ready);
      mirror.apply_request(act, ofs, wd, rxv, rxb);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_offset();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 80) return BASE + 16'(4 * $urandom_range(7));
      if (sel < 90) return BASE + 16'($urandom_range(31));
      return 16'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         mirror.compare_response({rsp_read_data, rsp_access_error, rsp_irq_level,
                                  rsp_tx_valid, rsp_tx_byte});
      end
   end

   // The receiver stops once for a long stretch so that the pipeline fills and stalls.
   initial begin
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!held && beats_sent >= 300) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
         end else begin
            rsp_ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   initial begin
      int unsigned sel;
      action_type  act;
      int          wait_cycles;
      mirror = new();
      beats_sent = 0;
      quiet = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_IDLE;
      req_offset <= '0;
      req_write_data <= '0;
      req_rx_valid <= 1'b0;
      req_rx_byte <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(ACT_READ, A_BUF, 32'h0, 1'b0, 8'h00);
      send_request(ACT_READ, A_IER, 32'h0, 1'b0, 8'h00);
      send_request(ACT_READ, A_FCR, 32'hffff_ffff, 1'b1, 8'hff);
      send_request(ACT_READ, A_LCR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_READ, A_LSR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_MCR, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_READ, A_MSR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_SCR, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_READ, 16'hffff, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, 16'h0000, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_BUF + 16'd1, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_IDLE, 16'hffff, 32'hffff_ffff, 1'b1, 8'hff);
      send_request(ACT_WRITE, A_IER, 32'hffff_ffff, 1'b1, 8'hff);
      send_request(ACT_TICK, 16'hffff, 32'hffff_ffff, 1'b1, 8'hff);
      send_request(ACT_READ, A_BUF, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_BUF, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_TICK, 16'h0000, 32'h0, 1'b1, 8'h5a);
      send_request(ACT_TICK, A_BUF, 32'h0, 1'b0, 8'hff);
      send_request(ACT_WRITE, A_LCR, 32'h0000_0080, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_BUF, 32'ha5a5_a5a5, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_IER, 32'h1234_5678, 1'b0, 8'h00);
      send_request(ACT_READ, A_BUF, 32'h0, 1'b0, 8'h00);
      send_request(ACT_READ, A_IER, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_FCR, 32'hffff_ffff, 1'b0, 8'h00);
      send_request(ACT_READ, A_FCR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_LCR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_WRITE, A_LSR, 32'h0, 1'b0, 8'h00);
      send_request(ACT_TICK, 16'h0000, 32'h0, 1'b0, 8'h00);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet <= (n >= 700 && n < 1000);
         sel = $urandom_range(99);
         if (sel < 34) act = ACT_READ;
         else if (sel < 68) act = ACT_WRITE;
         else if (sel < 95) act = ACT_TICK;
         else act = ACT_IDLE;
         send_request(act, pick_offset(), $urandom, 1'($urandom_range(1)), 8'($urandom));
      end
      req_valid <= 1'b0;
      quiet <= 1'b0;

      wait_cycles = 0;
      while (mirror.expected_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
